[rtl/core/mfd_pkg.sv]
// shared widths, marker codes, frame positions and types of the joint deframer
package mfd_pkg;

  localparam int ByteW = 8;
  localparam int PosW  = 6;
  localparam int SlotW = 3;
  localparam int RawW  = 15;
  localparam int DegW  = 20;

  // section marker bytes
  localparam logic signed [ByteW-1:0] MarkByteA = 8'sh80;  // -128
  localparam logic signed [ByteW-1:0] MarkByteB = 8'sh81;  // -127
  localparam logic signed [ByteW-1:0] MarkByteC = 8'sh82;  // -126

  // frame positions set by the markers
  localparam logic [PosW-1:0] MarkPosA = 6'd1;
  localparam logic [PosW-1:0] MarkPosB = 6'd17;
  localparam logic [PosW-1:0] MarkPosC = 6'd33;

  // positions that close a joint pair or the button pair
  localparam logic [PosW-1:0] JointFirstPos = 6'd34;
  localparam logic [PosW-1:0] JointLastPos  = 6'd44;
  localparam logic [PosW-1:0] ButtonPos     = 6'd46;

  // slot numbering
  localparam logic [PosW-2:0]  JointSlotBase = 5'd17;
  localparam logic [SlotW-1:0] ButtonSlot    = 3'd6;

  // one raw count is 45/256 degree
  localparam logic signed [DegW-1:0] DegPerCount = 20'sd45;

  // decoded pair handed from the frame tracker to the result stage
  typedef struct packed {
    logic                   emit;
    logic                   joint;
    logic [SlotW-1:0]       slot;
    logic signed [RawW-1:0] raw_value;
  } mfd_pair_t;

endpackage

[rtl/core/mfd_rx_if.sv]
// byte channel from the serial link
interface mfd_rx_if;
  import mfd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/core/mfd_res_if.sv]
// result channel carrying joint angles and the button word
interface mfd_res_if;
  import mfd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SlotW-1:0]       slot;
  logic signed [RawW-1:0] raw_value;
  logic signed [DegW-1:0] degrees_q8;

  modport source (output valid, output slot, output raw_value, output degrees_q8,
                  input ready);
  modport sink (input valid, input slot, input raw_value, input degrees_q8,
                output ready);
endinterface

[rtl/core/mfd_frame_tracker.sv]
// frame position and previous byte state, pair decode per received byte
module mfd_frame_tracker #(
  parameter int unsigned FRAME_LAST_POSITION = 51
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic signed [mfd_pkg::ByteW-1:0] rx_byte_i,
  output mfd_pkg::mfd_pair_t               pair_o,
  output logic [mfd_pkg::PosW-1:0]         pos_o
);
  import mfd_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LAST_POSITION);

  logic [PosW-1:0]         pos_q, pos_d;
  logic signed [ByteW-1:0] prev_q, prev_d;
  logic                    is_marker;
  logic [PosW-1:0]         mark_pos;
  logic                    is_joint;
  logic                    is_button;
  logic [PosW-2:0]         half_pos;

  // marker decode
  always_comb begin
    is_marker = 1'b1;
    mark_pos  = MarkPosA;
    unique case (rx_byte_i)
      MarkByteA: mark_pos = MarkPosA;
      MarkByteB: mark_pos = MarkPosB;
      MarkByteC: mark_pos = MarkPosC;
      default: begin
        is_marker = 1'b0;
        mark_pos  = MarkPosA;
      end
    endcase
  end

  // position class of the current byte
  assign is_joint  = (pos_q >= JointFirstPos) && (pos_q <= JointLastPos) && !pos_q[0];
  assign is_button = (pos_q == ButtonPos);
  assign half_pos  = pos_q[PosW-1:1] - JointSlotBase;

  // pair decode: 64*hi + lo
  always_comb begin
    pair_o.emit      = accept_i && !is_marker && (is_joint || is_button);
    pair_o.joint     = is_joint;
    pair_o.slot      = is_joint ? half_pos[SlotW-1:0] : ButtonSlot;
    pair_o.raw_value = {prev_q[ByteW-1], prev_q, 6'b0}
                     + {{(RawW-ByteW){rx_byte_i[ByteW-1]}}, rx_byte_i};
  end

  // next state
  always_comb begin
    pos_d  = pos_q;
    prev_d = prev_q;
    if (accept_i) begin
      if (is_marker) begin
        pos_d = mark_pos;
      end else begin
        prev_d = rx_byte_i;
        pos_d  = (pos_q >= LastPos) ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= '0;
    end else begin
      pos_q  <= pos_d;
      prev_q <= prev_d;
    end
  end

  assign pos_o = pos_q;

endmodule

[rtl/core/mfd_result_stage.sv]
// degree scaling and the result register with its handshake
module mfd_result_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfd_pkg::mfd_pair_t pair_i,
  output logic               take_o,
  mfd_res_if.source          res_o
);
  import mfd_pkg::*;

  logic                   valid_q, valid_d;
  logic [SlotW-1:0]       slot_q;
  logic signed [RawW-1:0] raw_q;
  logic signed [DegW-1:0] deg_q, deg_d;
  logic signed [DegW-1:0] raw_ext;

  // register can take a new result when empty or being drained
  assign take_o = !valid_q || res_o.ready;

  // raw count times 45, button word carries zero
  assign raw_ext = {{(DegW-RawW){pair_i.raw_value[RawW-1]}}, pair_i.raw_value};
  assign deg_d   = pair_i.joint ? raw_ext * DegPerCount : '0;

  assign valid_d = take_o ? pair_i.emit : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload loads only with a new result
  always_ff @(posedge clk_i) begin
    if (take_o && pair_i.emit) begin
      slot_q <= pair_i.slot;
      raw_q  <= pair_i.raw_value;
      deg_q  <= deg_d;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.slot       = slot_q;
  assign res_o.raw_value  = raw_q;
  assign res_o.degrees_q8 = deg_q;

endmodule

[rtl/core/marker_framed_joint_deframer.sv]
// top level of the marker framed joint deframer
//
// Takes one signed link byte per transaction and can accept a byte in every
// clock cycle unless its output register is full and not drained. Marker bytes
// -128, -127 and -126 set the frame position to 1, 17 or 33 and produce nothing.
// Any other byte joins the previously stored byte as 64*hi+lo; at even positions
// 34 to 44 this gives joint slots 0 to 5 with degrees_q8 = raw*45, at position 46
// the button word on slot 6 with degrees_q8 = 0. A result appears in the cycle
// after its byte is accepted, from a single output register; the byte input stays
// ready as long as that register is empty or is being drained in the same cycle.
module marker_framed_joint_deframer #(
  parameter int unsigned FRAME_LAST_POSITION = 51
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfd_rx_if.sink    rx_i,
  mfd_res_if.source res_o
);
  import mfd_pkg::*;

  mfd_pair_t       pair;
  logic            take;
  logic            accept;
  logic [PosW-1:0] pos;

  assign rx_i.ready = take;
  assign accept     = rx_i.valid && take;

  mfd_frame_tracker #(
    .FRAME_LAST_POSITION(FRAME_LAST_POSITION)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .pair_o    (pair),
    .pos_o     (pos)
  );

  mfd_result_stage u_result (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair),
    .take_o (take),
    .res_o  (res_o)
  );

`ifndef SYNTH
  // an accepted marker lands on one of the section starts
  a_marker_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (rx_i.rx_byte == MarkByteA || rx_i.rx_byte == MarkByteB
               || rx_i.rx_byte == MarkByteC)
    |=> (pos == MarkPosA || pos == MarkPosB || pos == MarkPosC))
    else $error("marker did not set a section start");

  // position never runs past the frame end
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos <= PosW'(FRAME_LAST_POSITION))
    else $error("frame position beyond frame end");

  // button word carries no angle
  a_button_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.slot == ButtonSlot |-> res_o.degrees_q8 == '0)
    else $error("button word with nonzero degrees");

  // joint angle is the raw count scaled by 45
  a_joint_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.slot != ButtonSlot
    |-> res_o.degrees_q8
        == {{(DegW-RawW){res_o.raw_value[RawW-1]}}, res_o.raw_value} * DegPerCount)
    else $error("joint degrees do not match raw count");
`endif

endmodule
